[rtl/servo_status_packet_receiver_defines.svh]
// ----------------------------------------------------------------------------
// Servo status packet receiver assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_RECEIVER_DEFINES_SVH
`define SERVO_STATUS_PACKET_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssp assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssp assertion failed");

`endif

[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver package
// Types, codes and limits shared by the receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

    localparam logic [7:0] MAX_LENGTH = 8'd32;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef enum logic [1:0] {
        ACT_BYTE = 2'd0,
        ACT_TICK = 2'd1,
        ACT_ARM  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_START_TIMEOUT = 3'd1,
        ST_BODY_TIMEOUT  = 3'd2,
        ST_BAD_LENGTH    = 3'd3,
        ST_CHECKSUM      = 3'd4,
        ST_ID_MISMATCH   = 3'd5,
        ST_SERVO_ERROR   = 3'd6
    } status_t;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_HDR1  = 8'b0000_0010,
        PH_HDR2  = 8'b0000_0100,
        PH_ID    = 8'b0000_1000,
        PH_LEN   = 8'b0001_0000,
        PH_ERR   = 8'b0010_0000,
        PH_PARAM = 8'b0100_0000,
        PH_CHK   = 8'b1000_0000
    } phase_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_ID = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WAIT    = 1'd1;

    typedef struct packed {
        phase_t     phase;
        logic [7:0] byte_count;
        logic [7:0] got_id;
        logic [7:0] got_length;
        logic [7:0] got_error;
        logic [7:0] running_sum;
        logic [7:0] wait_count;
    } rx_state_t;

    typedef struct packed {
        logic       done_res;
        logic [7:0] param_byte;
        logic [7:0] param_index;
        status_t    status;
        logic [7:0] resp_id;
        logic [7:0] servo_error;
    } result_t;

endpackage

`default_nettype wire

[rtl/ssp_step.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver step
// Next-state and result logic for one received byte, tick or arm item.
// ----------------------------------------------------------------------------
`default_nettype none

module ssp_step (
    input  var ssp_pkg::rx_state_t st,
    input  wire logic [1:0]        action,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [7:0]        expected_id,
    input  wire logic [7:0]        max_wait_ticks,
    output var ssp_pkg::rx_state_t st_next,
    output logic                   produce,
    output var ssp_pkg::result_t   res
);

    logic [7:0] wait_inc;
    logic [7:0] sum_add;
    logic [7:0] calc_sum;
    logic [8:0] count_inc;
    logic       early_phase;

    assign wait_inc    = (st.wait_count == 8'hFF) ? st.wait_count : st.wait_count + 8'd1;
    assign sum_add     = st.running_sum + rx_byte;
    assign calc_sum    = ~st.running_sum;
    assign count_inc   = {1'b0, st.byte_count} + 9'd1;
    assign early_phase = (st.phase == ssp_pkg::PH_HDR1) || (st.phase == ssp_pkg::PH_HDR2)
                      || (st.phase == ssp_pkg::PH_ID) || (st.phase == ssp_pkg::PH_LEN);

    always_comb
    begin
        st_next         = st;
        produce         = 1'b0;
        res.done_res    = 1'b0;
        res.param_byte  = 8'd0;
        res.param_index = st.byte_count;
        res.status      = ssp_pkg::ST_OK;
        res.resp_id     = st.got_id;
        res.servo_error = st.got_error;

        if (action == ssp_pkg::ACT_ARM)
        begin
            st_next.phase       = ssp_pkg::PH_HDR1;
            st_next.byte_count  = 8'd0;
            st_next.got_id      = 8'd0;
            st_next.got_length  = 8'd0;
            st_next.got_error   = 8'd0;
            st_next.running_sum = 8'd0;
            st_next.wait_count  = 8'd0;
        end
        else if (st.phase != ssp_pkg::PH_IDLE && action != ssp_pkg::ACT_NONE)
        begin
            if (action == ssp_pkg::ACT_TICK)
            begin
                st_next.wait_count = wait_inc;
                if (wait_inc > max_wait_ticks)
                begin
                    produce       = 1'b1;
                    res.done_res  = 1'b1;
                    res.status    = early_phase ? ssp_pkg::ST_START_TIMEOUT
                                                : ssp_pkg::ST_BODY_TIMEOUT;
                    st_next.phase = ssp_pkg::PH_IDLE;
                end
            end
            else
            begin
                case (st.phase)
                    ssp_pkg::PH_HDR1:
                    begin
                        st_next.phase = ssp_pkg::PH_HDR2;
                    end
                    ssp_pkg::PH_HDR2:
                    begin
                        st_next.phase = ssp_pkg::PH_ID;
                    end
                    ssp_pkg::PH_ID:
                    begin
                        st_next.got_id      = rx_byte;
                        st_next.running_sum = rx_byte;
                        st_next.phase       = ssp_pkg::PH_LEN;
                    end
                    ssp_pkg::PH_LEN:
                    begin
                        st_next.got_length  = rx_byte;
                        st_next.running_sum = sum_add;
                        st_next.wait_count  = 8'd0;
                        if (rx_byte > ssp_pkg::MAX_LENGTH || rx_byte < 8'd2)
                        begin
                            produce       = 1'b1;
                            res.done_res  = 1'b1;
                            res.status    = ssp_pkg::ST_BAD_LENGTH;
                            st_next.phase = ssp_pkg::PH_IDLE;
                        end
                        else
                        begin
                            st_next.phase = ssp_pkg::PH_ERR;
                        end
                    end
                    ssp_pkg::PH_ERR:
                    begin
                        st_next.got_error   = rx_byte;
                        st_next.running_sum = sum_add;
                        st_next.phase = (st.got_length > 8'd2) ? ssp_pkg::PH_PARAM
                                                               : ssp_pkg::PH_CHK;
                    end
                    ssp_pkg::PH_PARAM:
                    begin
                        st_next.running_sum = sum_add;
                        st_next.byte_count  = count_inc[7:0];
                        produce             = 1'b1;
                        res.param_byte      = rx_byte;
                        if (count_inc + 9'd2 >= {1'b0, st.got_length})
                        begin
                            st_next.phase = ssp_pkg::PH_CHK;
                        end
                    end
                    ssp_pkg::PH_CHK:
                    begin
                        produce       = 1'b1;
                        res.done_res  = 1'b1;
                        st_next.phase = ssp_pkg::PH_IDLE;
                        if (calc_sum != rx_byte)
                        begin
                            res.status = ssp_pkg::ST_CHECKSUM;
                        end
                        else if (st.got_id != expected_id)
                        begin
                            res.status = ssp_pkg::ST_ID_MISMATCH;
                        end
                        else if (st.got_error != 8'd0)
                        begin
                            res.status = ssp_pkg::ST_SERVO_ERROR;
                        end
                        else
                        begin
                            res.status = ssp_pkg::ST_OK;
                        end
                    end
                    default:
                    begin
                        st_next = st;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[rtl/servo_status_packet_receiver.sv]
// Result path: an item first sits in the input register, and the step logic loads the
//   result register from it when the input register advances.
// Throughput: one item per cycle; the input register advances whenever the result
//   register is free or the item gives no result.
// Reset: rst_n clears the receiver to idle, expected_id to 0, max_wait_ticks to 10.
// ----------------------------------------------------------------------------
// Servo status packet receiver
// Armed byte-wise parser of servo status packets with timeout and checks.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_status_packet_receiver (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      action,
    input  wire logic [7:0]                      rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 done_res,
    output logic [7:0]                           param_byte,
    output logic [7:0]                           param_index,
    output logic [2:0]                           status,
    output logic [7:0]                           resp_id,
    output logic [7:0]                           servo_error,
    input  wire logic                            cfg_we,
    input  wire logic [ssp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_wdata
);

    logic               s_valid_reg;
    logic [1:0]         s_action_reg;
    logic [7:0]         s_byte_reg;
    ssp_pkg::rx_state_t st_reg;
    ssp_pkg::rx_state_t st_next;
    logic               o_valid_reg;
    ssp_pkg::result_t   o_res_reg;
    ssp_pkg::result_t   res_next;
    logic               produce;
    logic [7:0]         expected_id_reg;
    logic [7:0]         max_wait_reg;
    logic               advance;

    ssp_step u_step (
        .st             (st_reg),
        .action         (s_action_reg),
        .rx_byte        (s_byte_reg),
        .expected_id    (expected_id_reg),
        .max_wait_ticks (max_wait_reg),
        .st_next        (st_next),
        .produce        (produce),
        .res            (res_next)
    );

    assign advance  = s_valid_reg && (!o_valid_reg || out_ready || !produce);
    assign in_ready = !s_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg <= 8'd0;
            max_wait_reg    <= 8'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ssp_pkg::CFG_EXPECTED_ID: expected_id_reg <= cfg_wdata;
                ssp_pkg::CFG_MAX_WAIT:    max_wait_reg    <= cfg_wdata;
                default:                  expected_id_reg <= expected_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg        <= 1'b0;
            o_valid_reg        <= 1'b0;
            st_reg.phase       <= ssp_pkg::PH_IDLE;
            st_reg.byte_count  <= 8'd0;
            st_reg.got_id      <= 8'd0;
            st_reg.got_length  <= 8'd0;
            st_reg.got_error   <= 8'd0;
            st_reg.running_sum <= 8'd0;
            st_reg.wait_count  <= 8'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                st_reg <= st_next;
            end

            if (advance && produce)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s_action_reg <= action;
            s_byte_reg   <= rx_byte;
        end
        if (advance && produce)
        begin
            o_res_reg <= res_next;
        end
    end

    assign out_valid   = o_valid_reg;
    assign done_res    = o_res_reg.done_res;
    assign param_byte  = o_res_reg.param_byte;
    assign param_index = o_res_reg.param_index;
    assign status      = o_res_reg.status;
    assign resp_id     = o_res_reg.resp_id;
    assign servo_error = o_res_reg.servo_error;

endmodule

`default_nettype wire

[rtl/ssp_checker.sv]
// ----------------------------------------------------------------------------
// Servo status packet receiver checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_status_packet_receiver_defines.svh"

module ssp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       done_res,
    input wire logic [7:0] param_byte,
    input wire logic [7:0] param_index,
    input wire logic [2:0] status
);

    `SSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `SSP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(done_res) && $stable(param_byte) && $stable(status))
    `SSP_ASSERT_IMPL(a_done_no_byte, out_valid && done_res, param_byte == 8'd0)
    `SSP_ASSERT_IMPL(a_param_ok, out_valid && !done_res, status == ssp_pkg::ST_OK)
    `SSP_ASSERT_IMPL(a_param_range, out_valid && !done_res, param_index < ssp_pkg::MAX_LENGTH - 8'd2)

endmodule

bind servo_status_packet_receiver ssp_checker u_ssp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .done_res    (done_res),
    .param_byte  (param_byte),
    .param_index (param_index),
    .status      (status)
);

`default_nettype wire
